FILE: hw/rtl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants for the IPD frame payload extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package ipd_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int PAYLOAD_CAP  = 64;
    localparam int MIN_HELD     = 7;
    localparam int TAG_LEN      = 5;

    localparam logic [6:0] MAX_PAYLOAD_RESET = 7'd64;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_FAIL
    } state_t;

    // "+IPD,"
    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h2B;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h2C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ipd_in_if.sv
// ----------------------------------------------------------------------------
// ipd_in_if
// Command channel: valid/ready with command and received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ipd_out_if.sv
// ----------------------------------------------------------------------------
// ipd_out_if
// Result channel: valid/ready with one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipd_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] payload_byte;
    logic [6:0] payload_length;
    logic       last;

    modport source (output valid, output found, output payload_byte,
                    output payload_length, output last, input ready);
    modport sink   (input valid, input found, input payload_byte,
                    input payload_length, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ipd_frame_payload_extractor.sv
// ----------------------------------------------------------------------------
// ipd_frame_payload_extractor
// Buffers received bytes and extracts the payload of the first +IPD frame.
// ----------------------------------------------------------------------------
// A received-byte, clear or unused command is taken whenever the block is
// idle. A read walks the buffer RAM byte by byte through ST_SCAN_RD and
// ST_SCAN_CHK, from index 0 up to the colon that ends the frame header (or
// the end of the held bytes), then hands out each payload byte through
// ST_EMIT_RD and ST_EMIT_LD, stalled by output backpressure; reads use the
// single registered read port of the buffer RAM. A failed read gives one beat
// with found low and leaves the buffer intact; a successful one empties it.
// The input is not ready while a read is in progress; the last result beat may
// still wait in the output register while new commands are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_frame_payload_extractor #(
    parameter int BUFFER_DEPTH = ipd_pkg::BUFFER_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [6:0] cfg_wr_data,
    ipd_in_if.sink          in_ch,
    ipd_out_if.source       out_ch
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    ipd_pkg::state_t state_reg, state_next;

    logic [6:0]    max_payload_reg;
    logic [AW-1:0] count_reg, count_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [2:0]    match_reg, match_next;
    logic          hdr_reg, hdr_next;
    logic [15:0]   acc_reg, acc_next;
    logic [6:0]    len_reg, len_next;
    logic [6:0]    rem_reg, rem_next;

    logic          out_valid_reg, out_valid_next;
    logic          found_reg, found_next;
    logic [7:0]    byte_reg, byte_next;
    logic [6:0]    length_reg, length_next;
    logic          last_reg, last_next;

    logic          ram_we;
    logic [7:0]    rdata;

    logic          in_fire;
    logic          slot_free;
    logic [6:0]    limit;
    logic          is_colon;
    logic          is_digit;
    logic [7:0]    digit_val;
    logic          scan_last;
    logic [AW-1:0] avail;
    logic          frame_ok;
    logic          read_bad;
    logic [15:0]   acc_mul;

    assign in_ch.ready = (state_reg == ipd_pkg::ST_IDLE);
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign limit     = (max_payload_reg > 7'(ipd_pkg::PAYLOAD_CAP))
                       ? 7'(ipd_pkg::PAYLOAD_CAP) : max_payload_reg;
    assign read_bad  = (limit == 7'd0) || (count_reg < AW'(ipd_pkg::MIN_HELD));
    assign is_colon  = hdr_reg && (rdata == ipd_pkg::CHAR_COLON);
    assign is_digit  = (rdata inside {[ipd_pkg::CHAR_ZERO:ipd_pkg::CHAR_NINE]});
    assign digit_val = rdata - ipd_pkg::CHAR_ZERO;
    assign acc_mul   = 16'(acc_reg * 16'd10);
    assign scan_last = (addr_reg == count_reg - AW'(1));
    assign avail     = count_reg - addr_reg - AW'(1);
    assign frame_ok  = (acc_reg != 16'd0) && (32'(avail) >= 32'(acc_reg));

    ipd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg),
        .wdata (in_ch.rx_byte),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ipd_pkg::ST_IDLE:
            begin
                if (in_fire && in_ch.command == ipd_pkg::CMD_READ)
                begin
                    state_next = read_bad ? ipd_pkg::ST_FAIL : ipd_pkg::ST_SCAN_RD;
                end
            end
            ipd_pkg::ST_SCAN_RD:
            begin
                state_next = ipd_pkg::ST_SCAN_CHK;
            end
            ipd_pkg::ST_SCAN_CHK:
            begin
                if (is_colon)
                begin
                    state_next = frame_ok ? ipd_pkg::ST_EMIT_RD : ipd_pkg::ST_FAIL;
                end
                else if (scan_last)
                begin
                    state_next = ipd_pkg::ST_FAIL;
                end
                else
                begin
                    state_next = ipd_pkg::ST_SCAN_RD;
                end
            end
            ipd_pkg::ST_EMIT_RD:
            begin
                state_next = ipd_pkg::ST_EMIT_LD;
            end
            ipd_pkg::ST_EMIT_LD:
            begin
                if (slot_free)
                begin
                    state_next = (rem_reg == 7'd1) ? ipd_pkg::ST_IDLE : ipd_pkg::ST_EMIT_RD;
                end
            end
            ipd_pkg::ST_FAIL:
            begin
                if (slot_free)
                begin
                    state_next = ipd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ipd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        addr_next      = addr_reg;
        match_next     = match_reg;
        hdr_next       = hdr_reg;
        acc_next       = acc_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        found_next     = found_reg;
        byte_next      = byte_reg;
        length_next    = length_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;

        case (state_reg)
            ipd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_ch.command)
                        ipd_pkg::CMD_BYTE:
                        begin
                            if (count_reg < AW'(BUFFER_DEPTH - 1))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + AW'(1);
                            end
                        end
                        ipd_pkg::CMD_READ:
                        begin
                            addr_next  = '0;
                            match_next = 3'd0;
                            hdr_next   = 1'b0;
                            acc_next   = 16'd0;
                        end
                        ipd_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ipd_pkg::ST_SCAN_CHK:
            begin
                if (!hdr_reg)
                begin
                    if (rdata == ipd_pkg::tag_char(match_reg))
                    begin
                        if (match_reg == 3'(ipd_pkg::TAG_LEN - 1))
                        begin
                            hdr_next = 1'b1;
                            acc_next = 16'd0;
                        end
                        match_next = match_reg + 3'd1;
                    end
                    else
                    begin
                        match_next = (rdata == ipd_pkg::CHAR_PLUS) ? 3'd1 : 3'd0;
                    end
                end
                else if (!is_colon)
                begin
                    acc_next = is_digit ? acc_mul + {8'd0, digit_val} : 16'd0;
                end

                if (is_colon)
                begin
                    len_next  = (acc_reg < 16'(limit)) ? 7'(acc_reg) : limit;
                    rem_next  = (acc_reg < 16'(limit)) ? 7'(acc_reg) : limit;
                    addr_next = addr_reg + AW'(1);
                end
                else if (!scan_last)
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ipd_pkg::ST_EMIT_LD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    byte_next      = rdata;
                    length_next    = len_reg;
                    last_next      = (rem_reg == 7'd1);
                    rem_next       = rem_reg - 7'd1;
                    addr_next      = addr_reg + AW'(1);
                    if (rem_reg == 7'd1)
                    begin
                        count_next = '0;
                    end
                end
            end
            ipd_pkg::ST_FAIL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    byte_next      = 8'd0;
                    length_next    = 7'd0;
                    last_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ipd_pkg::ST_IDLE;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            max_payload_reg <= ipd_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                max_payload_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        match_reg  <= match_next;
        hdr_reg    <= hdr_next;
        acc_reg    <= acc_next;
        len_reg    <= len_next;
        rem_reg    <= rem_next;
        found_reg  <= found_next;
        byte_reg   <= byte_next;
        length_reg <= length_next;
        last_reg   <= last_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.found          = found_reg;
    assign out_ch.payload_byte   = byte_reg;
    assign out_ch.payload_length = length_reg;
    assign out_ch.last           = last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ipd_ram.sv
// ----------------------------------------------------------------------------
// ipd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ipd_pkg::BUFFER_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
